FILE: rtl/core/iol_pkg.sv
// Package for the indexed ordered list: field widths, operation and status codes,
// and the command struct passed from the top level to the cell store.
// No dependencies.
package iol_pkg;

   // Field widths of the stream payloads
   localparam int KIND_W   = 2;
   localparam int POS_W    = 5;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   // Packed stream data widths, rounded up to whole bytes
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 40;

   // Operation kinds
   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_POS = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

   // Command from the request stage to the store
   typedef struct packed {
      logic              fire;
      logic [KIND_W-1:0] kind;
   } iol_cmd_type;

endpackage

FILE: rtl/core/iol_store.sv
// Cell store of the indexed ordered list: a row of shift cells and the entry count.
// Works out status, removed value and new count for one command per cycle.
// Depends on iol_pkg.
module iol_store #(
   parameter int CAPACITY   = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  iol_pkg::iol_cmd_type          cmd,
   input  logic [iol_pkg::POS_W-1:0]     position,
   input  logic [DATA_WIDTH-1:0]         value,
   output logic [DATA_WIDTH-1:0]         removed_value,
   output logic [iol_pkg::STATUS_W-1:0]  status,
   output logic [iol_pkg::COUNT_W-1:0]   count
);
   import iol_pkg::*;

   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int IW   = $clog2(CAPACITY);
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [DATA_WIDTH-1:0] cell_ff [CAPACITY];
   logic [CMPW-1:0]       pos_x, cnt_x;
   logic                  ins_ok, rm_ok;

   assign pos_x = CMPW'(position);
   assign cnt_x = CMPW'(cnt_ff);

   // Status, new count and which shift to do
   always_comb begin
      status        = ST_OK;
      cnt_in        = cnt_ff;
      ins_ok        = 1'b0;
      rm_ok         = 1'b0;
      removed_value = '0;
      case (cmd.kind)
         KIND_INSERT: begin
            if (pos_x > cnt_x) begin
               status = ST_BAD_POS;
            end else if (cnt_ff == CAP_C) begin
               status = ST_FULL;
            end else begin
               ins_ok = cmd.fire;
               cnt_in = cnt_ff + 1'b1;
            end
         end
         KIND_REMOVE: begin
            if (pos_x > cnt_x) begin
               status = ST_BAD_POS;
            end else if (cnt_ff == '0) begin
               status = ST_EMPTY;
            end else if (pos_x == cnt_x) begin
               status = ST_BAD_POS;
            end else begin
               rm_ok         = cmd.fire;
               cnt_in        = cnt_ff - 1'b1;
               removed_value = cell_ff[pos_x[IW-1:0]];
            end
         end
         KIND_CLEAR: begin
            cnt_in = '0;
         end
         default: begin
            // unused kind: no change
         end
      endcase
   end

   assign count = COUNT_W'(cnt_in);

   // Entry count
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.fire) begin
         cnt_ff <= cnt_in;
      end
   end

   // Shifting cells take the left neighbour on insert, the right one on remove
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      localparam logic [CMPW-1:0] IDX = CMPW'(g);
      logic [DATA_WIDTH-1:0] prev_cell, next_cell, cell_in;

      if (g == 0) begin : g_first
         assign prev_cell = value;
      end else begin : g_mid
         assign prev_cell = cell_ff[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign next_cell = cell_ff[g];
      end else begin : g_body
         assign next_cell = cell_ff[g+1];
      end

      always_comb begin
         cell_in = cell_ff[g];
         if (ins_ok) begin
            if (pos_x == IDX) begin
               cell_in = value;
            end else if (pos_x < IDX) begin
               cell_in = prev_cell;
            end
         end else if (rm_ok && (pos_x <= IDX)) begin
            cell_in = next_cell;
         end
      end

      always_ff @(posedge clock) begin
         cell_ff[g] <= cell_in;
      end
   end

endmodule

FILE: rtl/core/indexed_ordered_list.sv
// Top level of the indexed ordered list: request register, cell store, result register.
// Depends on iol_pkg and iol_store.
//
//   channel | direction | tdata (low bit up)                   | tuser
//   req     | in        | position[4:0], value[36:5]            | kind[1:0]
//   rsp     | out       | removed_value[31:0], status[33:32],   | -
//           |           | count[38:34]                          |
//
// One item per cycle while results drain; each goes via the request and result registers.
// All cells shift or hold in parallel within the cycle between the request
// register and the result register, so the rate is set by that single pass.
// Reset empties the list; cell contents are not cleared and need no pass.
// A stalled result holds the request register, which still takes one item.
module indexed_ordered_list #(
   parameter int CAPACITY   = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [iol_pkg::REQ_TDATA_W-1:0]   req_tdata,  // position, value, zero pad
   input  logic [iol_pkg::KIND_W-1:0]        req_tuser,  // kind
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [iol_pkg::RSP_TDATA_W-1:0]   rsp_tdata   // removed_value, status, count, pad
);
   import iol_pkg::*;

   logic                 req_valid_ff, req_valid_in;
   logic [KIND_W-1:0]    req_kind_ff;
   logic [POS_W-1:0]     req_pos_ff;
   logic [VALUE_W-1:0]   req_value_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0] rsp_removed_ff, rsp_removed_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   logic                 advance, req_xfer;
   iol_cmd_type          cmd;
   logic [DATA_WIDTH-1:0] store_removed;

   // Handshake: the pass runs whenever the result register is free or draining
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !req_valid_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;

   assign req_valid_in = req_xfer ? 1'b1 : (advance ? 1'b0 : req_valid_ff);

   // Request register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         req_kind_ff  <= req_tuser;
         req_pos_ff   <= req_tdata[POS_W-1:0];
         req_value_ff <= req_tdata[POS_W+VALUE_W-1:POS_W];
      end
   end

   // Store
   assign cmd.fire = req_valid_ff && advance;
   assign cmd.kind = req_kind_ff;

   iol_store #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_store (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .position      (req_pos_ff),
      .value         (DATA_WIDTH'(req_value_ff)),
      .removed_value (store_removed),
      .status        (rsp_status_in),
      .count         (rsp_count_in)
   );

   assign rsp_removed_in = VALUE_W'(store_removed);
   assign rsp_valid_in   = cmd.fire ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fire) begin
         rsp_removed_ff <= rsp_removed_in;
         rsp_status_ff  <= rsp_status_in;
         rsp_count_ff   <= rsp_count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - VALUE_W - STATUS_W - COUNT_W){1'b0}},
                        rsp_count_ff, rsp_status_ff, rsp_removed_ff};

`ifndef NO_ASSERTIONS
   // A failed operation never returns a value
   a_err_no_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != ST_OK)) |-> (rsp_removed_ff == '0))
      else $error("error result carries a removed value");

   // A request held back by a stalled result keeps its payload
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && !advance) |=> (req_valid_ff && $stable(req_pos_ff)
                                      && $stable(req_kind_ff)))
      else $error("stalled request changed");

   // A full status reports the list at capacity
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == ST_FULL)) |-> (rsp_count_ff == COUNT_W'(CAPACITY)))
      else $error("full status with count below capacity");
`endif

endmodule
